>>> sv/cfvd_pkg.sv
// ============================================================================
// cfvd_pkg - shared types and constants for the CRC-16 frame deframer
// Register indexes, status codes, type codes, FSM states and the CRC fold.
// ============================================================================
`default_nettype none

package cfvd_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } t_state;

    // configuration register indexes
    localparam logic [2:0] CFG_LINK_LIMIT = 3'd0;
    localparam logic [2:0] CFG_HELLO_MIN  = 3'd1;
    localparam logic [2:0] CFG_TYPE_SHIFT = 3'd2;
    localparam logic [2:0] CFG_SEQ_INDEX  = 3'd3;
    localparam logic [2:0] CFG_ACK_INDEX  = 3'd4;

    // result status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_SHORT    = 3'd1;
    localparam logic [2:0] STAT_OVER_CAP = 3'd2;
    localparam logic [2:0] STAT_LEN_MISM = 3'd3;
    localparam logic [2:0] STAT_CRC      = 3'd4;
    localparam logic [2:0] STAT_RSV_TYPE = 3'd5;
    localparam logic [2:0] STAT_LINK_LIM = 3'd6;
    localparam logic [2:0] STAT_HELLO_SH = 3'd7;

    // frame type codes
    localparam logic [2:0] TYPE_HELLO   = 3'd0;
    localparam logic [2:0] TYPE_WELCOME = 3'd1;
    localparam logic [2:0] TYPE_LINK    = 3'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // one byte into CRC-16, MSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/crc16_frame_validator_deframer_unit.sv
// ============================================================================
// crc16_frame_validator_deframer_unit - CRC-16 framed packet decoder
// Checks control/length/payload/CRC frames and replays the payload bytes.
// ============================================================================
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+--------------------------
//  input    | i_rx_byte, i_end_of_block                | start & !busy
//  result   | o_status .. o_final_result               | o_strobe, one cycle
//  config   | i_cfg_index, i_cfg_data                  | i_cfg_valid & o_cfg_ready
//
//  Flow: a non-final byte is taken whenever the block is idle (byte-wide CRC
//  fold, one memory write). The final byte leads to the check state, then to
//  the result state, one payload memory read per cycle; busy stays high meanwhile.
//  Reset: synchronous, active low; no clearing pass, payload entries are
//  always written before they are read.
//  Stalls: the receiver cannot stall; each result request is shown once.
//
`default_nettype none

module crc16_frame_validator_deframer_unit #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte requests
    input  wire logic       start,
    output logic            busy,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_end_of_block,
    // result requests
    output logic            o_strobe,
    output logic [2:0]      o_status,
    output logic [1:0]      o_frame_type,
    output logic            o_seq_flag,
    output logic            o_ack_flag,
    output logic [6:0]      o_payload_length,
    output logic [7:0]      o_payload_byte,
    output logic            o_byte_present,
    output logic            o_final_result,
    // config requests
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data
);
    import cfvd_pkg::*;

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [7:0] MAX8 = 8'(PAYLOAD_DEPTH);

    // ---------------- configuration ----------------
    logic [6:0] r_link_limit, r_hello_min;
    logic [2:0] r_type_shift, r_seq_idx, r_ack_idx;

    assign o_cfg_ready = 1'b1;  // writes must only arrive while idle; the block does not enforce it

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_limit <= 7'd64;
            r_hello_min  <= 7'd0;
            r_type_shift <= 3'd5;
            r_seq_idx    <= 3'd1;
            r_ack_idx    <= 3'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LINK_LIMIT: r_link_limit <= i_cfg_data;
                CFG_HELLO_MIN:  r_hello_min  <= i_cfg_data;
                CFG_TYPE_SHIFT: r_type_shift <= i_cfg_data[2:0];
                CFG_SEQ_INDEX:  r_seq_idx    <= i_cfg_data[2:0];
                CFG_ACK_INDEX:  r_ack_idx    <= i_cfg_data[2:0];
                default: ;      // unmapped index, dropped
            endcase
        end
    end

    // ---------------- control ----------------
    t_state r_state, n_state;
    logic   accept;
    logic   [AW-1:0] r_idx, r_last;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        busy     = 1'b1;
        o_strobe = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (accept && i_end_of_block) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_strobe = 1'b1;
                if (r_idx == r_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- per-block state ----------------
    logic [7:0]  r_cnt, r_ctrl, r_len;
    logic [15:0] r_crc, r_rx_crc;
    logic [8:0]  len_p2;
    logic        crc_en;

    assign len_p2 = {1'b0, r_len} + 9'd2;
    // bytes before the CRC position implied by the length byte
    assign crc_en = (r_cnt < 8'd2) || ({1'b0, r_cnt} < len_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ctrl   <= '0;
            r_len    <= '0;
            r_crc    <= CRC_INIT;
            r_rx_crc <= '0;
        end else if (accept) begin
            if (r_cnt == 8'd0) begin
                r_ctrl <= i_rx_byte;
            end
            if (r_cnt == 8'd1) begin
                r_len <= i_rx_byte;
            end
            if (crc_en) begin
                r_crc <= crc_fold(r_crc, i_rx_byte);
            end
            r_rx_crc <= {r_rx_crc[7:0], i_rx_byte};   // last two bytes, big endian
            if (r_cnt != 8'hFF) begin
                r_cnt <= r_cnt + 8'd1;                // saturates at 255
            end
        end else if (r_state == ST_CHECK) begin
            // header has been captured for emission; start fresh
            r_cnt    <= '0;
            r_ctrl   <= '0;
            r_len    <= '0;
            r_crc    <= CRC_INIT;
            r_rx_crc <= '0;
        end
    end

    // ---------------- payload memory ----------------
    logic [7:0]    mem [PAYLOAD_DEPTH];
    logic [7:0]    r_rd_data;
    logic [7:0]    pay_off;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;

    assign pay_off = r_cnt - 8'd2;
    assign wr_en   = accept && (r_cnt >= 8'd2) && (pay_off < r_len) && (pay_off < MAX8);
    assign wr_addr = pay_off[AW-1:0];

    // CHECK fetches entry 0; each EMIT cycle but the last fetches the next one
    always_comb begin
        if (r_state == ST_EMIT && r_idx != r_last) begin
            rd_addr = AW'(r_idx + AW'(1));
        end else if (r_state == ST_EMIT) begin
            rd_addr = r_idx;
        end else begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_rx_byte;
        end
        r_rd_data <= mem[rd_addr];
    end

    // ---------------- frame checks ----------------
    logic [7:0] ctrl_sh;
    logic [2:0] ftype;
    logic       ok, has_bytes;
    logic [2:0] status;

    assign ctrl_sh = r_ctrl >> r_type_shift;
    assign ftype   = ctrl_sh[2:0];

    always_comb begin
        priority if (r_cnt < 8'd4) begin
            status = STAT_SHORT;
        end else if (r_len > MAX8) begin
            status = STAT_OVER_CAP;
        end else if ({1'b0, r_cnt} != ({1'b0, r_len} + 9'd4)) begin
            status = STAT_LEN_MISM;
        end else if (r_crc != r_rx_crc) begin
            status = STAT_CRC;
        end else if (ftype[2]) begin
            status = STAT_RSV_TYPE;
        end else if (ftype == TYPE_LINK && r_len > {1'b0, r_link_limit}) begin
            status = STAT_LINK_LIM;
        end else if ((ftype == TYPE_HELLO || ftype == TYPE_WELCOME)
                     && r_len < {1'b0, r_hello_min}) begin
            status = STAT_HELLO_SH;
        end else begin
            status = STAT_OK;
        end
    end

    assign ok        = (status == STAT_OK);
    assign has_bytes = ok && (r_len != 8'd0);

    // ---------------- emission ----------------
    logic [2:0] r_status;
    logic [1:0] r_type;
    logic       r_seq, r_ack, r_bytes;
    logic [6:0] r_out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_last <= '0;
        end else if (r_state == ST_CHECK) begin
            r_idx  <= '0;
            r_last <= has_bytes ? AW'(r_len - 8'd1) : '0;
        end else if (r_state == ST_EMIT) begin
            r_idx  <= rd_addr;
        end
    end

    // rejected frames carry a zeroed header
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHECK) begin
            r_status  <= status;
            r_type    <= ok ? ftype[1:0] : 2'd0;
            r_seq     <= ok && r_ctrl[r_seq_idx];
            r_ack     <= ok && r_ctrl[r_ack_idx];
            r_out_len <= ok ? r_len[6:0] : 7'd0;
            r_bytes   <= has_bytes;
        end
    end

    assign o_status         = r_status;
    assign o_frame_type     = r_type;
    assign o_seq_flag       = r_seq;
    assign o_ack_flag       = r_ack;
    assign o_payload_length = r_out_len;
    assign o_payload_byte   = r_bytes ? r_rd_data : 8'd0;
    assign o_byte_present   = r_bytes;
    assign o_final_result   = (r_idx == r_last);

endmodule

`default_nettype wire

>>> sv/cfvd_checker.sv
// ============================================================================
// cfvd_checker - port-level checks for the CRC-16 frame deframer
// Watches the request ports over time; attached by bind.
// ============================================================================
`default_nettype none

module cfvd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       i_end_of_block,
    input wire logic       o_strobe,
    input wire logic [2:0] o_status,
    input wire logic [1:0] o_frame_type,
    input wire logic [6:0] o_payload_length,
    input wire logic       o_byte_present,
    input wire logic       o_final_result
);
    import cfvd_pkg::*;

    // results only appear while a block is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while not busy");

    // a final byte is followed by the check state, no result yet
    a_last_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_end_of_block) |=> (busy && !o_strobe))
        else $error("no check cycle after final byte");

    // a rejection is a single, final result without payload
    a_reject_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != STAT_OK) |-> (o_final_result && !o_byte_present))
        else $error("rejection not a single final result");

    // the final result ends the burst and frees the block
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_final_result) |=> (!o_strobe && !busy))
        else $error("results continue after final");

    // within one burst the header stays put
    a_hdr_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_final_result) |=>
            (o_strobe && $stable(o_frame_type) && $stable(o_payload_length)))
        else $error("header changed inside a burst");

endmodule

bind crc16_frame_validator_deframer_unit cfvd_checker u_cfvd_checker (.*);

`default_nettype wire
